>>> rtl/core/ppbm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ppbm_pkg
// Shared types and constants for the priority packet buffer manager.
// ============================================================================
package ppbm_pkg;

    localparam int BUFFERS    = 64;
    localparam int CATEGORIES = 8;
    localparam int CAT_BITS   = 3;
    localparam int LEN_BITS   = 12;
    localparam int DS_BITS    = 6;
    localparam int ID_BITS    = 6;
    localparam int CAT_SHIFT  = 3;

    localparam logic [0:0] REG_EGRESS_ENABLE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_WRITE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic read;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
    } dp_status_t;

endpackage

>>> rtl/core/ppbm_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// ppbm_ctrl
// Sequencer: load, head scan, memory read, commit.
// ============================================================================
module ppbm_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output ppbm_pkg::dp_cmd_t   cmd,
    input  ppbm_pkg::dp_status_t status
);
    import ppbm_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start) state_next = ST_SCAN;
            ST_SCAN:  if (status.scan_done) state_next = ST_READ;
            ST_READ:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_SCAN:  cmd.scan   = 1'b1;
            ST_READ:  cmd.read   = 1'b1;
            ST_WRITE: cmd.commit = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

endmodule

>>> rtl/core/ppbm_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// ppbm_datapath
// Queue memory, length memory, pointers, head scan and allocation.
// ============================================================================
module ppbm_datapath
#(
    parameter int ORDER_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  ppbm_pkg::dp_cmd_t            cmd,
    output ppbm_pkg::dp_status_t         status,
    input  logic                         egress_enable,
    input  logic                         packet_valid,
    input  logic [ppbm_pkg::LEN_BITS-1:0] packet_length,
    input  logic [ppbm_pkg::DS_BITS-1:0] diffserv,
    input  logic                         returned_valid,
    input  logic [ppbm_pkg::ID_BITS-1:0] returned_id,
    input  logic                         egress_ready,
    output logic                         done,
    output logic                         assigned_valid,
    output logic [ppbm_pkg::ID_BITS-1:0] assigned_id,
    output logic                         returned_taken,
    output logic                         dropped,
    output logic                         sent_valid,
    output logic [ppbm_pkg::ID_BITS-1:0] sent_id,
    output logic [ppbm_pkg::LEN_BITS-1:0] sent_length,
    output logic                         no_buffer_error
);
    import ppbm_pkg::*;

    localparam int SLOT_BITS = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
    localparam int PTR_BITS  = SLOT_BITS + 1;
    localparam int BID_BITS  = SLOT_BITS;
    localparam int ENT_BITS  = BID_BITS + ORDER_BITS;
    localparam int CNT_BITS  = $clog2(BUFFERS + 1);
    localparam logic [PTR_BITS-1:0] SPAN_LAST = PTR_BITS'(2 * BUFFERS - 1);

    logic [ENT_BITS-1:0] qmem [0:CATEGORIES*BUFFERS-1];
    logic [LEN_BITS-1:0] lmem [0:BUFFERS-1];

    logic [PTR_BITS-1:0]   head_reg [CATEGORIES];
    logic [PTR_BITS-1:0]   tail_reg [CATEGORIES];
    logic [ORDER_BITS-1:0] next_order_reg;
    logic [ORDER_BITS-1:0] last_sent_reg;
    logic [CNT_BITS-1:0]   fresh_reg;

    // latched item
    logic                 ing_reg, rv_reg, rdy_reg;
    logic [LEN_BITS-1:0]  len_reg;
    logic [CAT_BITS-1:0]  cat_reg;
    logic [ID_BITS-1:0]   rid_reg;

    // scan
    logic [CAT_BITS-1:0]   scan_idx_reg;
    logic [ENT_BITS-1:0]   qrd_reg;
    logic                  qrd_vld_reg;
    logic [CAT_BITS-1:0]   qrd_cat_reg;
    logic                  best_vld_reg;
    logic [CAT_BITS-1:0]   best_cat_reg;
    logic [ORDER_BITS-1:0] best_age_reg, best_ord_reg;
    logic [BID_BITS-1:0]   best_id_reg;
    logic                  drop_vld_reg;
    logic [CAT_BITS-1:0]   drop_cat_reg;
    logic [BID_BITS-1:0]   drop_id_reg;
    logic [LEN_BITS-1:0]   len_rd_reg;
    logic                  scan_last_reg;

    function automatic logic [SLOT_BITS-1:0] slot(input logic [PTR_BITS-1:0] p);
        logic [PTR_BITS-1:0] s;
        s = (p >= PTR_BITS'(BUFFERS)) ? p - PTR_BITS'(BUFFERS) : p;
        return s[SLOT_BITS-1:0];
    endfunction

    function automatic logic [PTR_BITS-1:0] adv(input logic [PTR_BITS-1:0] p);
        return (p == SPAN_LAST) ? '0 : p + 1'b1;
    endfunction

    logic nonempty [CATEGORIES];
    always_comb
    begin
        for (int c = 0; c < CATEGORIES; c++)
            nonempty[c] = head_reg[c] != tail_reg[c];
    end

    // occupancy of target category
    logic [PTR_BITS-1:0] occ;
    logic                full;
    always_comb
    begin
        occ = (tail_reg[cat_reg] >= head_reg[cat_reg])
            ? tail_reg[cat_reg] - head_reg[cat_reg]
            : tail_reg[cat_reg] + PTR_BITS'(2 * BUFFERS) - head_reg[cat_reg];
        full = occ >= PTR_BITS'(BUFFERS);
    end

    logic rid_ok;
    assign rid_ok = ({{(32-ID_BITS){1'b0}}, rid_reg} < 32'(BUFFERS));

    // allocation decision
    logic                have, taken, err, drop_now;
    logic [BID_BITS-1:0] wid;
    always_comb
    begin
        have = 1'b0; taken = 1'b0; err = 1'b0; drop_now = 1'b0; wid = '0;
        if (ing_reg)
        begin
            priority if (full) err = 1'b1;
            else if (rv_reg && rid_ok)
            begin
                wid = rid_reg[BID_BITS-1:0]; taken = 1'b1; have = 1'b1;
            end
            else if (fresh_reg < CNT_BITS'(BUFFERS))
            begin
                wid = fresh_reg[BID_BITS-1:0]; have = 1'b1;
            end
            else if (drop_vld_reg)
            begin
                wid = drop_id_reg; have = 1'b1; drop_now = 1'b1;
            end
            else err = 1'b1;
        end
    end

    logic send;
    assign send = best_vld_reg && egress_enable && rdy_reg
               && !(drop_now && drop_cat_reg == best_cat_reg);

    assign status.scan_done = scan_last_reg;

    // memories
    always_ff @(posedge clk)
    begin
        qrd_reg <= qmem[{scan_idx_reg, slot(head_reg[scan_idx_reg])}];
        len_rd_reg <= lmem[best_id_reg];
        if (cmd.commit && have)
        begin
            qmem[{cat_reg, slot(tail_reg[cat_reg])}] <= {wid, next_order_reg};
            lmem[wid] <= len_reg;
        end
    end

    logic [ORDER_BITS-1:0] age;
    assign age = qrd_reg[ORDER_BITS-1:0] - last_sent_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ing_reg <= packet_valid; rv_reg <= returned_valid;
            rdy_reg <= egress_ready; len_reg <= packet_length;
            cat_reg <= diffserv[CAT_SHIFT +: CAT_BITS]; rid_reg <= returned_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CATEGORIES; c++)
            begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
            end
            next_order_reg <= '0;
            last_sent_reg  <= '1;
            fresh_reg      <= '0;
            scan_idx_reg   <= '0;
            qrd_vld_reg    <= 1'b0;
            qrd_cat_reg    <= '0;
            scan_last_reg  <= 1'b0;
            best_vld_reg   <= 1'b0;
            drop_vld_reg   <= 1'b0;
            best_cat_reg   <= '0;
            best_age_reg   <= '0;
            best_ord_reg   <= '0;
            best_id_reg    <= '0;
            drop_cat_reg   <= '0;
            drop_id_reg    <= '0;
            done           <= 1'b0;
            assigned_valid <= 1'b0;
            assigned_id    <= '0;
            returned_taken <= 1'b0;
            dropped        <= 1'b0;
            sent_valid     <= 1'b0;
            sent_id        <= '0;
            sent_length    <= '0;
            no_buffer_error <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (cmd.load)
            begin
                scan_idx_reg  <= '0;
                qrd_vld_reg   <= 1'b0;
                scan_last_reg <= 1'b0;
                best_vld_reg  <= 1'b0;
                drop_vld_reg  <= 1'b0;
            end
            if (cmd.scan)
            begin
                // one category issued per cycle, evaluated in the cycle after
                qrd_vld_reg <= nonempty[scan_idx_reg] && !scan_last_reg;
                qrd_cat_reg <= scan_idx_reg;
                if (scan_idx_reg == CAT_BITS'(CATEGORIES - 1))
                    scan_last_reg <= 1'b1;
                else
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                if (qrd_vld_reg)
                begin
                    if (!best_vld_reg || age < best_age_reg)
                    begin
                        best_vld_reg <= 1'b1;
                        best_cat_reg <= qrd_cat_reg;
                        best_age_reg <= age;
                        best_ord_reg <= qrd_reg[ORDER_BITS-1:0];
                        best_id_reg  <= qrd_reg[ORDER_BITS +: BID_BITS];
                    end
                    if (!drop_vld_reg)
                    begin
                        drop_vld_reg <= 1'b1;
                        drop_cat_reg <= qrd_cat_reg;
                        drop_id_reg  <= qrd_reg[ORDER_BITS +: BID_BITS];
                    end
                end
            end
            if (cmd.commit)
            begin
                done <= 1'b1;
                if (have)
                begin
                    tail_reg[cat_reg] <= adv(tail_reg[cat_reg]);
                    next_order_reg    <= next_order_reg + 1'b1;
                    if (!taken && !drop_now)
                        fresh_reg <= fresh_reg + 1'b1;
                end
                if (drop_now)
                    head_reg[drop_cat_reg] <= adv(head_reg[drop_cat_reg]);
                if (send)
                begin
                    head_reg[best_cat_reg] <= adv(head_reg[best_cat_reg]);
                    last_sent_reg <= best_ord_reg;
                end
                assigned_valid  <= have;
                assigned_id     <= have ? ID_BITS'(wid) : '0;
                returned_taken  <= taken;
                dropped         <= drop_now;
                sent_valid      <= send;
                sent_id         <= send ? ID_BITS'(best_id_reg) : '0;
                sent_length     <= send ? len_rd_reg : '0;
                no_buffer_error <= err;
            end
        end
    end

endmodule

>>> rtl/core/priority_packet_buffer_manager.sv
`timescale 1ns / 1ps
// ============================================================================
// priority_packet_buffer_manager
// Buffer id allocation with per-category FIFOs and low-priority drop.
// ============================================================================
// A step is issued with start while busy is low. From start to the done
// strobe it passes through load, a scan of the eight category heads
// through the single read port of the queue memory, a read of the length
// memory, a commit into the memories and pointers, then the registered
// result. The result ports hold a transfer for exactly one cycle, flagged
// by done; the receiver cannot stall, so capture it then. A new start is
// taken in the cycle done is high. egress_enable sits at address 0 of the
// APB port and resets to 1; write it only while the block is idle.
module priority_packet_buffer_manager
#(
    parameter int ORDER_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [1:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    output logic                          done,
    input  logic                          packet_valid,
    input  logic [ppbm_pkg::LEN_BITS-1:0] packet_length,
    input  logic [ppbm_pkg::DS_BITS-1:0]  diffserv,
    input  logic                          returned_valid,
    input  logic [ppbm_pkg::ID_BITS-1:0]  returned_id,
    input  logic                          egress_ready,
    output logic                          assigned_valid,
    output logic [ppbm_pkg::ID_BITS-1:0]  assigned_id,
    output logic                          returned_taken,
    output logic                          dropped,
    output logic                          sent_valid,
    output logic [ppbm_pkg::ID_BITS-1:0]  sent_id,
    output logic [ppbm_pkg::LEN_BITS-1:0] sent_length,
    output logic                          no_buffer_error
);
    import ppbm_pkg::*;

    // byte address of the register: four bytes per register
    localparam logic [1:0] ADDR_EGRESS_ENABLE = 2'(4 * REG_EGRESS_ENABLE);

    logic       egress_enable_reg;
    dp_cmd_t    cmd;
    dp_status_t status;

    assign pready = 1'b1;

    // register file: only egress_enable exists
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            egress_enable_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && paddr == ADDR_EGRESS_ENABLE)
        begin
            egress_enable_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr == ADDR_EGRESS_ENABLE) ? {31'd0, egress_enable_reg} : '0;

    ppbm_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    ppbm_datapath #(.ORDER_BITS(ORDER_BITS)) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .egress_enable   (egress_enable_reg),
        .packet_valid    (packet_valid),
        .packet_length   (packet_length),
        .diffserv        (diffserv),
        .returned_valid  (returned_valid),
        .returned_id     (returned_id),
        .egress_ready    (egress_ready),
        .done            (done),
        .assigned_valid  (assigned_valid),
        .assigned_id     (assigned_id),
        .returned_taken  (returned_taken),
        .dropped         (dropped),
        .sent_valid      (sent_valid),
        .sent_id         (sent_id),
        .sent_length     (sent_length),
        .no_buffer_error (no_buffer_error)
    );

endmodule

>>> rtl/core/ppbm_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// ppbm_checker
// Port-level temporal checks for the buffer manager.
// ============================================================================
module ppbm_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic assigned_valid,
    input logic returned_taken,
    input logic dropped,
    input logic no_buffer_error
);
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");
    a_taken_assign: assert property (@(posedge clk) disable iff (!rst_n)
        done && returned_taken |-> assigned_valid) else $error("taken without assign");
    a_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done && no_buffer_error |-> !assigned_valid && !dropped)
        else $error("error with allocation");
endmodule

bind priority_packet_buffer_manager ppbm_checker u_chk
(
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .assigned_valid(assigned_valid), .returned_taken(returned_taken),
    .dropped(dropped), .no_buffer_error(no_buffer_error)
);

>>> test/tb_priority_packet_buffer_manager.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_priority_packet_buffer_manager
// Self-checking bench for the priority packet buffer manager.
// ============================================================================
// Steps go in through the start/busy command port and are mirrored in a
// behavioral copy of the buffer manager: per-category id rings, length store,
// order counters and fresh id count. Each predicted step is queued, and every
// done strobe is compared field by field with the oldest queued step. A short
// table of directed steps opens the run. Phases follow with egress_enable
// toggled over the APB port while the block is idle:
//   - fill with egress off (fresh ids run out, low categories get dropped)
//   - mixed random traffic with egress on
//   - duplicate returned ids into the top category until its ring is full
//   - drain, then arrivals with nothing to recover
//   - a final stretch of mixed random traffic
// ============================================================================
module tb_priority_packet_buffer_manager;

    import ppbm_pkg::*;

    localparam int NBUF       = 64;
    localparam int WATCHDOG   = 4000;
    localparam int DONE_DELAY = 13;
    localparam logic [1:0] ADDR_EGRESS_ENABLE = 2'(4 * REG_EGRESS_ENABLE);

    // one step of the block: inputs and the single result it produces
    typedef struct {
        logic                ing;
        logic [LEN_BITS-1:0] len;
        logic [DS_BITS-1:0]  ds;
        logic                rv;
        logic [ID_BITS-1:0]  rid;
        logic                rdy;
    } step_in_t;

    typedef struct {
        logic                av;
        logic [ID_BITS-1:0]  aid;
        logic                rt;
        logic                dr;
        logic                sv;
        logic [ID_BITS-1:0]  sid;
        logic [LEN_BITS-1:0] slen;
        logic                err;
    } step_out_t;

    // directed row: inputs, then a flag for a hand-typed result and that result
    typedef struct {
        logic                ing;
        logic [LEN_BITS-1:0] len;
        logic [DS_BITS-1:0]  ds;
        logic                rv;
        logic [ID_BITS-1:0]  rid;
        logic                rdy;
        bit                  typed;
        step_out_t           res;
    } dir_row_t;

    localparam step_out_t NONE = '{1'b0, 6'd0, 1'b0, 1'b0, 1'b0, 6'd0, 12'd0, 1'b0};

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [1:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                start;
    logic                busy;
    logic                done;
    logic                packet_valid;
    logic [LEN_BITS-1:0] packet_length;
    logic [DS_BITS-1:0]  diffserv;
    logic                returned_valid;
    logic [ID_BITS-1:0]  returned_id;
    logic                egress_ready;
    logic                assigned_valid;
    logic [ID_BITS-1:0]  assigned_id;
    logic                returned_taken;
    logic                dropped;
    logic                sent_valid;
    logic [ID_BITS-1:0]  sent_id;
    logic [LEN_BITS-1:0] sent_length;
    logic                no_buffer_error;

    priority_packet_buffer_manager i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .start           (start),
        .busy            (busy),
        .done            (done),
        .packet_valid    (packet_valid),
        .packet_length   (packet_length),
        .diffserv        (diffserv),
        .returned_valid  (returned_valid),
        .returned_id     (returned_id),
        .egress_ready    (egress_ready),
        .assigned_valid  (assigned_valid),
        .assigned_id     (assigned_id),
        .returned_taken  (returned_taken),
        .dropped         (dropped),
        .sent_valid      (sent_valid),
        .sent_id         (sent_id),
        .sent_length     (sent_length),
        .no_buffer_error (no_buffer_error)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Mirror of the manager state
    // ------------------------------------------------------------------------
    logic [ID_BITS-1:0]  ring_id  [CATEGORIES][NBUF];
    logic [15:0]         ring_ord [CATEGORIES][NBUF];
    logic [LEN_BITS-1:0] buf_len  [NBUF];
    logic [6:0]          head_ptr [CATEGORIES];
    logic [6:0]          tail_ptr [CATEGORIES];
    logic [15:0]         order_next;
    logic [15:0]         order_last_sent;
    logic [6:0]          fresh_used;
    logic                egress_on;

    step_out_t pending_results[$];
    int        fail_count;
    bit        no_idle;

    // pointers count modulo 128 with a wrap bit; the slot is the low 6 bits
    function automatic int queued_total();
        int n;
        n = 0;
        for (int c = 0; c < CATEGORIES; c++)
            n += 7'(tail_ptr[c] - head_ptr[c]);
        return n;
    endfunction

    task automatic manager_step(input step_in_t s, output step_out_t o);
        int                  best;
        int                  drop_c;
        int                  cat;
        logic [15:0]         age;
        logic [15:0]         best_age;
        logic [15:0]         best_ord;
        logic [ID_BITS-1:0]  best_id;
        logic [LEN_BITS-1:0] best_len;
        logic [ID_BITS-1:0]  wid;
        bit                  have;
        bit                  snd;
        best     = -1;
        drop_c   = -1;
        best_age = '0;
        best_ord = '0;
        best_id  = '0;
        best_len = '0;
        wid      = '0;
        have     = 1'b0;
        o        = NONE;
        cat      = int'(s.ds >> CAT_SHIFT);

        // oldest head by modular age; strict compare keeps the lowest on ties
        for (int c = 0; c < CATEGORIES; c++)
        begin
            if (head_ptr[c] != tail_ptr[c])
            begin
                age = ring_ord[c][head_ptr[c][5:0]] - order_last_sent;
                if (best < 0 || age < best_age)
                begin
                    best     = c;
                    best_age = age;
                    best_ord = ring_ord[c][head_ptr[c][5:0]];
                    best_id  = ring_id[c][head_ptr[c][5:0]];
                end
            end
        end
        if (best >= 0)
            best_len = buf_len[best_id];   // read before this step's write

        if (s.ing)
        begin
            if (7'(tail_ptr[cat] - head_ptr[cat]) >= 7'(NBUF))
                o.err = 1'b1;              // target ring full, no entry can be queued
            else if (s.rv)
            begin
                wid  = s.rid;
                o.rt = 1'b1;
                have = 1'b1;
            end
            else if (fresh_used < 7'(NBUF))
            begin
                wid        = fresh_used[5:0];
                fresh_used = fresh_used + 7'd1;
                have       = 1'b1;
            end
            else
            begin
                for (int c = CATEGORIES - 1; c >= 0; c--)
                    if (head_ptr[c] != tail_ptr[c])
                        drop_c = c;
                if (drop_c >= 0)
                begin
                    wid  = ring_id[drop_c][head_ptr[drop_c][5:0]];
                    have = 1'b1;
                end
                else
                    o.err = 1'b1;
            end
        end

        if (have)
        begin
            ring_id[cat][tail_ptr[cat][5:0]]  = wid;
            ring_ord[cat][tail_ptr[cat][5:0]] = order_next;
            tail_ptr[cat]                     = tail_ptr[cat] + 7'd1;
            order_next                        = order_next + 16'd1;
            buf_len[wid]                      = s.len;
        end

        // a packet dropped this step is never also sent
        snd = best >= 0 && egress_on && s.rdy && best != drop_c;
        if (drop_c >= 0)
            head_ptr[drop_c] = head_ptr[drop_c] + 7'd1;
        if (snd)
        begin
            head_ptr[best]  = head_ptr[best] + 7'd1;
            order_last_sent = best_ord;
        end

        o.av   = have;
        o.aid  = have ? wid : '0;
        o.dr   = drop_c >= 0;
        o.sv   = snd;
        o.sid  = snd ? best_id : '0;
        o.slen = snd ? best_len : '0;
    endtask

    // ------------------------------------------------------------------------
    // Command side: drive at the falling edge, one transfer per call
    // ------------------------------------------------------------------------
    // busy only moves at the rising edge, so its value here is the value the
    // block sees at the next rising edge: start high now means accepted then.
    task automatic issue_step(input step_in_t s, input bit typed, input step_out_t res);
        step_out_t o;
        forever
        begin
            @(negedge clk);
            if ((!no_idle && $urandom_range(0, 99) < 10) || busy)
                start <= 1'b0;
            else
                break;
        end
        packet_valid   <= s.ing;
        packet_length  <= s.len;
        diffserv       <= s.ds;
        returned_valid <= s.rv;
        returned_id    <= s.rid;
        egress_ready   <= s.rdy;
        start          <= 1'b1;
        manager_step(s, o);
        pending_results.push_back(typed ? res : o);
    endtask

    task automatic random_step(input int p_ing, input int p_rv, input int ds_lo,
                               input int ds_hi);
        step_in_t s;
        s.ing = $urandom_range(0, 99) < p_ing;
        case ($urandom_range(0, 9))
            0:       s.len = 12'd0;
            1:       s.len = 12'd2048;
            default: s.len = 12'($urandom_range(0, 2048));
        endcase
        s.ds  = 6'($urandom_range(ds_lo, ds_hi));
        s.rv  = $urandom_range(0, 99) < p_rv;
        s.rid = 6'($urandom_range(0, NBUF - 1));
        s.rdy = $urandom_range(0, 99) < 60;
        issue_step(s, 1'b0, NONE);
    endtask

    // drop start, then wait out every outstanding transfer
    task automatic quiesce();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // APB write: setup then access; pready is always high
    task automatic write_egress_enable(input logic value);
        quiesce();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_EGRESS_ENABLE;
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        egress_on = value;
    endtask

    // ------------------------------------------------------------------------
    // Result side: the block cannot be stalled, so every done is a transfer
    // ------------------------------------------------------------------------
    int idle_cycles;

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        step_out_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no step outstanding");
                fail_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("assigned_valid", e.av, assigned_valid);
                check_field("assigned_id", e.aid, assigned_id);
                check_field("returned_taken", e.rt, returned_taken);
                check_field("dropped", e.dr, dropped);
                check_field("sent_valid", e.sv, sent_valid);
                check_field("sent_id", e.sid, sent_id);
                check_field("sent_length", e.slen, sent_length);
                check_field("no_buffer_error", e.err, no_buffer_error);
            end
        end
        // watchdog: cycles with neither a step taken nor a result seen
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Directed steps, from reset. Typed results are the obvious ones: idle
    // steps, the first fresh id, a returned id taken, the top-length send.
    // ------------------------------------------------------------------------
    dir_row_t dir_rows [22] = '{
        // idle right after reset: nothing queued, nothing sent
        '{0, 0,    0,  0, 0,  0, 1, NONE},
        // first arrival takes fresh id 0, length 2048, top diffserv
        '{1, 2048, 63, 0, 0,  0, 1, '{1, 0,  0, 0, 0, 0, 0,    0}},
        // offered id 63 wins over fresh; the queued id 0 goes out
        '{1, 0,    0,  1, 63, 1, 1, '{1, 63, 1, 0, 1, 0, 2048, 0}},
        // offer without arrival is not taken; id 63 goes out
        '{0, 5,    0,  1, 7,  1, 1, '{0, 0,  0, 0, 1, 63, 0,   0}},
        '{0, 0,    0,  0, 0,  1, 1, NONE},
        // duplicate offered ids across categories
        '{1, 2048, 8,  1, 63, 0, 0, NONE},
        '{1, 1,    16, 1, 63, 0, 0, NONE},
        '{1, 100,  24, 0, 0,  0, 0, NONE},
        '{1, 200,  32, 0, 0,  1, 0, NONE},
        '{1, 300,  40, 0, 0,  1, 0, NONE},
        '{1, 400,  48, 0, 0,  0, 0, NONE},
        '{1, 500,  56, 0, 0,  1, 0, NONE},
        '{1, 7,    7,  0, 0,  1, 0, NONE},
        '{0, 0,    0,  0, 0,  1, 0, NONE},
        '{0, 0,    0,  0, 0,  1, 0, NONE},
        // same-step arrival and send; length write must not leak into the send
        '{1, 2047, 31, 1, 0,  1, 0, NONE},
        '{1, 1,    57, 0, 0,  0, 0, NONE},
        '{1, 1024, 42, 1, 42, 1, 0, NONE},
        '{0, 0,    0,  0, 0,  1, 0, NONE},
        '{0, 0,    0,  0, 0,  1, 0, NONE},
        '{0, 0,    0,  0, 0,  1, 0, NONE},
        '{0, 0,    0,  0, 0,  1, 0, NONE}
    };

    initial
    begin
        step_in_t s;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        start          = 1'b0;
        packet_valid   = 1'b0;
        packet_length  = '0;
        diffserv       = '0;
        returned_valid = 1'b0;
        returned_id    = '0;
        egress_ready   = 1'b0;
        fail_count     = 0;
        no_idle        = 1'b0;
        idle_cycles    = 0;
        for (int c = 0; c < CATEGORIES; c++)
        begin
            head_ptr[c] = '0;
            tail_ptr[c] = '0;
        end
        order_next      = '0;
        order_last_sent = '1;
        fresh_used      = '0;
        egress_on       = 1'b1;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            s = '{dir_rows[i].ing, dir_rows[i].len, dir_rows[i].ds,
                  dir_rows[i].rv, dir_rows[i].rid, dir_rows[i].rdy};
            issue_step(s, dir_rows[i].typed, dir_rows[i].res);
        end

        // egress off: fresh ids run out, then the lowest category gets dropped
        write_egress_enable(1'b0);
        repeat (100) random_step(95, 10, 0, 63);

        // egress on: drops, returns and sends interleave; drop may hit the send
        write_egress_enable(1'b1);
        for (int i = 0; i < 900; i++)
        begin
            no_idle = i >= 300 && i < 500;
            random_step(70, 30, 0, 63);
        end
        no_idle = 1'b0;

        // top category fed only by duplicate returned ids until its ring is full
        write_egress_enable(1'b0);
        repeat (80) random_step(100, 100, 56, 63);

        // drain everything, then arrive with no offer, no fresh id, no head
        write_egress_enable(1'b1);
        while (queued_total() != 0)
        begin
            s = '{1'b0, 12'd0, 6'd0, 1'($urandom_range(0, 1)), 6'($urandom), 1'b1};
            issue_step(s, 1'b0, NONE);
        end
        repeat (4)
        begin
            s = '{1'b1, 12'($urandom_range(0, 2048)), 6'($urandom), 1'b0, 6'd0,
                  1'($urandom_range(0, 1))};
            issue_step(s, 1'b0, NONE);
        end

        repeat (600) random_step(60, 40, 0, 63);

        quiesce();
        repeat (2 * DONE_DELAY) @(negedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
